@@ src/spq_pkg.sv @@
package spq_pkg;

  // colour channel and result widths
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned PIXEL_W = 3 * CHAN_W;
  localparam int unsigned SQ_W    = 2 * CHAN_W;
  localparam int unsigned DIST_W  = SQ_W + 2;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // request sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } spq_state_t;

endpackage

@@ src/stripe_palette_quantizer_core.sv @@
// Adaptive palette quantizer. A request (start high while busy is low) carries one RGB pixel
// and a stripe_start flag that empties the palette and clears the substitution count first.
// The palette sits in a single-port memory with a registered read, and is scanned one entry
// per cycle in index order. An exact match stops the scan. Without a match, every entry is
// scanned; with an empty palette the request goes straight to its finish. A new request may be
// accepted in the cycle that shows done.
// The result is on colour_index, was_new, was_substituted and substitutions in the cycle that
// done is high for a single cycle, and the receiver cannot stall it.
module stripe_palette_quantizer_core
  import spq_pkg::*;
#(
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                stripe_start,
  input  logic [CHAN_W-1:0]   red,
  input  logic [CHAN_W-1:0]   green,
  input  logic [CHAN_W-1:0]   blue,
  output logic                done,
  output logic [INDEX_W-1:0]  colour_index,
  output logic                was_new,
  output logic                was_substituted,
  output logic [COUNT_W-1:0]  substitutions
);

  localparam int unsigned AW    = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int unsigned FW    = $clog2(PALETTE_SIZE + 1);
  localparam int unsigned IDX_W = (AW > INDEX_W) ? AW : INDEX_W;

  // palette memory
  logic [PIXEL_W-1:0] palette_mem [PALETTE_SIZE];
  logic [PIXEL_W-1:0] mem_q;

  // control state
  spq_state_t         state;
  spq_state_t         state_next;
  logic [FW-1:0]      fill;
  logic [FW-1:0]      rd_idx;
  logic [COUNT_W-1:0] sub_count;

  // captured pixel
  logic [PIXEL_W-1:0] pixel;

  // scan pipeline
  logic               s1_vld;
  logic [AW-1:0]      s1_idx;
  logic               s2_vld;
  logic [AW-1:0]      s2_idx;
  logic [SQ_W-1:0]    s2_sq_r;
  logic [SQ_W-1:0]    s2_sq_g;
  logic [SQ_W-1:0]    s2_sq_b;
  logic               best_vld;
  logic [DIST_W-1:0]  best_dist;
  logic [AW-1:0]      best_idx;
  logic               found;
  logic [AW-1:0]      found_idx;

  // combinational control
  logic               accept;
  logic               issue;
  logic               s1_match;
  logic               scan_drained;
  logic [CHAN_W-1:0]  d_r;
  logic [CHAN_W-1:0]  d_g;
  logic [CHAN_W-1:0]  d_b;
  logic [DIST_W-1:0]  s2_dist;
  logic               palette_full;
  logic [IDX_W-1:0]   result_idx;

  assign accept       = start && !busy;
  assign s1_match     = s1_vld && (mem_q == pixel);
  assign scan_drained = (rd_idx >= fill) && !s1_vld && !s2_vld;
  assign palette_full = (fill >= FW'(PALETTE_SIZE));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (s1_match || scan_drained) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b0;
    issue = 1'b0;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_SCAN: begin
        busy  = 1'b1;
        issue = (rd_idx < fill) && !s1_match;
      end
      ST_FINISH: begin
        busy = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // memory read and append
  always_ff @(posedge clk) begin
    if (issue) mem_q <= palette_mem[rd_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && !found && !palette_full) begin
      palette_mem[fill[AW-1:0]] <= pixel;
    end
  end

  // capture pixel on request
  always_ff @(posedge clk) begin
    if (accept) pixel <= {blue, green, red};
  end

  // read address counter
  always_ff @(posedge clk) begin
    if (rst)        rd_idx <= '0;
    else if (accept) rd_idx <= '0;
    else if (issue)  rd_idx <= rd_idx + FW'(1);
  end

  // stage 1: match check and squared channel differences
  always_comb begin
    d_r = (mem_q[CHAN_W-1:0] > pixel[CHAN_W-1:0]) ?
          mem_q[CHAN_W-1:0] - pixel[CHAN_W-1:0] : pixel[CHAN_W-1:0] - mem_q[CHAN_W-1:0];
    d_g = (mem_q[2*CHAN_W-1:CHAN_W] > pixel[2*CHAN_W-1:CHAN_W]) ?
          mem_q[2*CHAN_W-1:CHAN_W] - pixel[2*CHAN_W-1:CHAN_W] :
          pixel[2*CHAN_W-1:CHAN_W] - mem_q[2*CHAN_W-1:CHAN_W];
    d_b = (mem_q[PIXEL_W-1:2*CHAN_W] > pixel[PIXEL_W-1:2*CHAN_W]) ?
          mem_q[PIXEL_W-1:2*CHAN_W] - pixel[PIXEL_W-1:2*CHAN_W] :
          pixel[PIXEL_W-1:2*CHAN_W] - mem_q[PIXEL_W-1:2*CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (rst || state != ST_SCAN) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      s1_vld <= issue;
      s2_vld <= s1_vld && !s1_match;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) s1_idx <= rd_idx[AW-1:0];
    s2_idx  <= s1_idx;
    s2_sq_r <= d_r * d_r;
    s2_sq_g <= d_g * d_g;
    s2_sq_b <= d_b * d_b;
  end

  // stage 2: distance and running minimum, earliest entry wins ties
  assign s2_dist = DIST_W'(s2_sq_r) + DIST_W'(s2_sq_g) + DIST_W'(s2_sq_b);

  always_ff @(posedge clk) begin
    if (rst || accept) begin
      best_vld <= 1'b0;
    end else if (state == ST_SCAN && s2_vld && (!best_vld || s2_dist < best_dist)) begin
      best_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && s2_vld && (!best_vld || s2_dist < best_dist)) begin
      best_dist <= s2_dist;
      best_idx  <= s2_idx;
    end
  end

  // exact match
  always_ff @(posedge clk) begin
    if (rst || accept)                  found <= 1'b0;
    else if (state == ST_SCAN && s1_match) found <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && s1_match) found_idx <= s1_idx;
  end

  // palette fill and substitution count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      sub_count <= '0;
    end else if (accept && stripe_start) begin
      fill      <= '0;
      sub_count <= '0;
    end else if (state == ST_FINISH && !found) begin
      if (!palette_full) begin
        fill <= fill + FW'(1);
      end else if (sub_count != COUNT_MAX) begin
        sub_count <= sub_count + COUNT_W'(1);
      end
    end
  end

  // result registers
  always_comb begin
    if (found)             result_idx = IDX_W'(found_idx);
    else if (!palette_full) result_idx = IDX_W'(fill);
    else                   result_idx = IDX_W'(best_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= (state == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH) begin
      colour_index    <= result_idx[INDEX_W-1:0];
      was_new         <= !found && !palette_full;
      was_substituted <= !found && palette_full;
      if (!found && palette_full && sub_count != COUNT_MAX) begin
        substitutions <= sub_count + COUNT_W'(1);
      end else begin
        substitutions <= sub_count;
      end
    end
  end

endmodule

@@ src/spq_checker.sv @@
module spq_checker
  import spq_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               was_new,
  input logic               was_substituted,
  input logic [COUNT_W-1:0] substitutions
);

  // a result appears only once the block has gone idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // busy only rises after a request
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy without request");

  // a pixel is either appended or substituted, never both
  a_flags: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_new && was_substituted))
    else $error("new and substituted together");

  // a substitution never leaves the count at zero
  a_count: assert property (@(posedge clk) disable iff (rst)
    (done && was_substituted) |-> (substitutions != '0))
    else $error("substitution with zero count");

endmodule

bind stripe_palette_quantizer_core spq_checker u_spq_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .was_new         (was_new),
  .was_substituted (was_substituted),
  .substitutions   (substitutions)
);
